FILE: hdl/dhkc_pkg.sv
// Shared constants, payload types and control structs for the double-hash key counter.
package dhkc_pkg;

  localparam int TABLE_SIZE = 4093;
  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int KEY_W = 32;
  localparam int CNT_W = 32;
  localparam int STATUS_W = 3;

  // hash reduction: 33-bit value folded on 2^12 = 3 mod 4093 and 2^12 = 4 mod 4092,
  // three folds then one conditional subtract
  localparam int VAL_W = KEY_W + 1;
  localparam int MOD_STEPS = 3;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [SLOT_W-1:0] TS_SLOT = SLOT_W'(TABLE_SIZE);
  localparam logic [SLOT_W:0] TS_EXT = (SLOT_W + 1)'(TABLE_SIZE);
  localparam logic [VAL_W-1:0] TS_VAL = VAL_W'(TABLE_SIZE);
  localparam logic [VAL_W-1:0] TS_M1_VAL = VAL_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W-1:0] MOD_LAST = SLOT_W'(MOD_STEPS - 1);

  localparam logic [VAL_W-1:0] OFS_FIRST = VAL_W'(17);
  localparam logic [VAL_W-1:0] OFS_STEP = VAL_W'(17239);
  localparam logic signed [KEY_W-1:0] MIN_KEY = -32'sd2147466408;

  localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic kind;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0] occurrences;
    logic [11:0] slot;
  } out_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic rd;
    logic advance;
    logic wr_new;
    logic wr_hit;
    logic clr_start;
    logic clr_wr;
    logic emit;
    logic [STATUS_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic mod_done;
    logic empty;
    logic match;
    logic probe_last;
    logic clr_last;
  } sts_t;

endpackage

FILE: hdl/dhkc_dpath.sv
// Datapath: hash reduction, probe address, key and count memories, result register.
module dhkc_dpath import dhkc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  in_t  item,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t result
);

  logic [KEY_W-1:0] key_mem [TABLE_SIZE];
  logic [CNT_W-1:0] cnt_mem [TABLE_SIZE];

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] fv, sv;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [SLOT_W-1:0] pos, step, probe_n, clr_addr;
  logic [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0] rd_cnt;

  logic [VAL_W-1:0] mag, first_val, second_val;
  logic [VAL_W-1:0] fv_fold, sv_fold;
  logic [SLOT_W:0] sum_w;
  logic [SLOT_W-1:0] ra_next, rb_next, pos_adv;
  logic [CNT_W-1:0] cnt_inc;
  logic [SLOT_W-1:0] wr_addr;

  assign mag = {1'b1, {KEY_W{1'b0}}} - {1'b0, item.key};
  assign first_val = item.key[KEY_W-1] ? mag + OFS_FIRST : {1'b0, item.key};
  assign second_val = item.key[KEY_W-1] ? mag + OFS_STEP : {1'b0, item.key};

  // fold the bits above 12 back in: times 3 for mod 4093, times 4 for mod 4092
  assign fv_fold = VAL_W'({fv[VAL_W-1:SLOT_W], 1'b0}) + VAL_W'(fv[VAL_W-1:SLOT_W])
                 + VAL_W'(fv[SLOT_W-1:0]);
  assign sv_fold = VAL_W'({sv[VAL_W-1:SLOT_W], 2'b00}) + VAL_W'(sv[SLOT_W-1:0]);
  assign ra_next = (fv_fold >= TS_VAL) ? SLOT_W'(fv_fold - TS_VAL) : fv_fold[SLOT_W-1:0];
  assign rb_next = (sv_fold >= TS_M1_VAL) ? SLOT_W'(sv_fold - TS_M1_VAL)
                                          : sv_fold[SLOT_W-1:0];

  assign sum_w = {1'b0, pos} + {1'b0, step};
  assign pos_adv = (sum_w >= TS_EXT) ? SLOT_W'(sum_w - TS_EXT) : sum_w[SLOT_W-1:0];
  assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_W'(1);
  assign wr_addr = cmd.clr_wr ? clr_addr : pos;

  assign sts.ignore = (item.key == '0) || (item.key < MIN_KEY);
  assign sts.mod_done = ({{(SLOT_W - MOD_CNT_W){1'b0}}, mod_cnt} == MOD_LAST);
  assign sts.empty = (rd_key == '0);
  assign sts.match = (rd_key == key_r);
  assign sts.probe_last = (probe_n == TS_SLOT - SLOT_W'(1));
  assign sts.clr_last = (clr_addr == TS_SLOT - SLOT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= item.key;
      fv <= first_val;
      sv <= second_val;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      fv <= fv_fold;
      sv <= sv_fold;
      mod_cnt <= mod_cnt + MOD_CNT_W'(1);
      if (sts.mod_done) begin
        pos <= ra_next;
        step <= rb_next + SLOT_W'(1);
        probe_n <= '0;
      end
    end else if (cmd.advance) begin
      pos <= pos_adv;
      probe_n <= probe_n + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.wr_new) begin
      key_mem[wr_addr] <= cmd.clr_wr ? '0 : key_r;
    end
    if (cmd.wr_new || cmd.wr_hit) begin
      cnt_mem[pos] <= cmd.wr_new ? CNT_W'(1) : cnt_inc;
    end
    if (cmd.rd) begin
      rd_key <= key_mem[pos];
      rd_cnt <= cnt_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status <= cmd.code;
      case (cmd.code)
        ST_NEW: begin
          result.occurrences <= CNT_W'(1);
          result.slot <= 12'(pos);
        end
        ST_HIT: begin
          result.occurrences <= cnt_inc;
          result.slot <= 12'(pos);
        end
        default: begin
          result.occurrences <= '0;
          result.slot <= '0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> pos < TS_SLOT) else $error("probe address out of table");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (step != '0) && (step < TS_SLOT)) else $error("bad probe step");
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.mod_step && sts.mod_done) |->
      (fv_fold < VAL_W'(2 * TABLE_SIZE)) && (sv_fold < VAL_W'(2 * (TABLE_SIZE - 1))))
    else $error("hash fold not reduced");
`endif

endmodule

FILE: hdl/dhkc_ctrl.sv
// Controller state machine: clear sweep, hash reduction, probe loop, result strobe.
module dhkc_ctrl import dhkc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_CHECK
  } state_t;

  state_t state, state_next;
  logic clr_item;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.code = ST_IGNORED;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
          cmd.emit = clr_item;
          cmd.code = ST_CLEARED;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (kind) begin
            cmd.clr_start = 1'b1;
            state_next = S_CLR;
          end else if (sts.ignore) begin
            cmd.emit = 1'b1;
            cmd.code = ST_IGNORED;
          end else begin
            cmd.load = 1'b1;
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_next = S_PROBE;
      end
      S_PROBE: begin
        cmd.rd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.empty) begin
          cmd.wr_new = 1'b1;
          cmd.emit = 1'b1;
          cmd.code = ST_NEW;
          state_next = S_IDLE;
        end else if (sts.match) begin
          cmd.wr_hit = 1'b1;
          cmd.emit = 1'b1;
          cmd.code = ST_HIT;
          state_next = S_IDLE;
        end else if (sts.probe_last) begin
          cmd.emit = 1'b1;
          cmd.code = ST_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next = S_PROBE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_item <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= cmd.emit;
      if (cmd.clr_start) begin
        clr_item <= 1'b1;
      end else if (state == S_CLR && sts.clr_last) begin
        clr_item <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy)) else $error("item accepted but dropped");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> done) else $error("result strobe missing");
`endif

endmodule

FILE: hdl/double_hash_key_counter_unit.sv
// Top level of the double-hash key counter: controller plus datapath.
// Usage: an item is taken when start is high and busy is low; its single result
// appears on result with done high for one cycle and cannot be held off. After
// reset the block sweeps all 4093 table slots empty, one slot per cycle, with
// busy high. A clear item runs the same sweep and then strobes its result. A
// zero or out-of-range key is answered the cycle after it is taken and busy
// stays low. A counted key goes through hash reduction (the 33-bit value folded
// three times against both moduli, then one conditional subtract), then probes,
// each a registered table read and then a compare and write; done follows in the
// cycle after the last probe. The registered table read sets the probe rate.
module double_hash_key_counter_unit import dhkc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  item,
  output logic busy,
  output logic done,
  output out_t result
);

  cmd_t cmd;
  sts_t sts;

  dhkc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dhkc_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule
